/* rtl/assert_macros.svh */
// ============================================================================
// assert_macros.svh
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked only while reset is released.
`define LLFA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define LLFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LLFA_ASSERT(lbl, clk, rst_n, prop, msg)
`define LLFA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/llfa_pkg.sv */
// ============================================================================
// llfa_pkg
// Shared widths, types and reset values of the least-loaded fold assigner.
// ============================================================================
package llfa_pkg;

    localparam int MAX_FOLDS_DEF = 16;
    localparam int LOAD_W        = 32;
    localparam int SIZE_W        = 16;
    localparam int FOLD_IDX_W    = 4;
    localparam int FOLD_COUNT_W  = 5;

    localparam logic [FOLD_COUNT_W-1:0] FOLD_COUNT_RST = 5'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] group_size;
        logic              first_of_set;
    } in_item_t;

    typedef struct packed {
        logic [FOLD_IDX_W-1:0] fold_index;
        logic [LOAD_W-1:0]     range_start;
        logic [LOAD_W-1:0]     range_end;
        logic                  saturated;
    } out_item_t;

    // Broadcast control to every cell of the load ring.
    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctrl_t;

endpackage

/* rtl/llfa_cell.sv */
// ============================================================================
// llfa_cell
// One fold-load cell of the ring: clears on a new set, shifts toward the head.
// ============================================================================
module llfa_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  llfa_pkg::cell_ctrl_t       ctrl,
    input  logic [llfa_pkg::LOAD_W-1:0] d,
    output logic [llfa_pkg::LOAD_W-1:0] q
);
    import llfa_pkg::*;

    logic [LOAD_W-1:0] load_reg;
    logic [LOAD_W-1:0] load_next;

    always_comb
    begin
        load_next = load_reg;
        if (ctrl.clr)
        begin
            load_next = '0;
        end
        else if (ctrl.shift)
        begin
            load_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg <= '0;
        end
        else
        begin
            load_reg <= load_next;
        end
    end

    assign q = load_reg;

endmodule

/* rtl/least_loaded_fold_assigner_core.sv */
// ============================================================================
// least_loaded_fold_assigner_core
// Assigns each group to the least-loaded fold and reports its index range.
// ============================================================================
//  channel  | signals                    | direction
//  ---------+----------------------------+----------
//  in       | in_valid, in_stall, in_item   | sink
//  out      | out_valid, out_stall, out_item | source
//  cfg      | cfg_we, cfg_wdata          | sink
//
//  A transaction steps through accept, one ring rotation to find the minimum
//  load, one rotation to add the size to the chosen fold, then loading the
//  output register. The ring of MAX_FOLDS load cells shifts one place per
//  cycle during the scan and update passes, past a single head comparator
//  and adder.
//  Reset clears all loads and the offset and sets fold_count to 2, at once.
//  A stalled result waits in the output register while the next transaction
//  is accepted; its own result then waits until the register frees up.
module least_loaded_fold_assigner_core #(
    parameter int MAX_FOLDS = llfa_pkg::MAX_FOLDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  llfa_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output llfa_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [llfa_pkg::FOLD_COUNT_W-1:0]   cfg_wdata
);
    import llfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_FOLDS);
    localparam int CW    = (IDX_W + 1 > FOLD_COUNT_W) ? IDX_W + 1 : FOLD_COUNT_W;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_FOLDS - 1);
    localparam logic [CW-1:0]    FOLD_LIMIT = CW'(MAX_FOLDS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        step_reg, step_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic [LOAD_W-1:0]       best_load_reg, best_load_next;
    logic [LOAD_W-1:0]       offset_reg, offset_next;
    logic [FOLD_COUNT_W-1:0] fold_count_reg, fold_count_next;
    logic                    out_valid_reg, out_valid_next;

    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [LOAD_W-1:0]       start_reg, start_next;
    logic [LOAD_W-1:0]       end_reg, end_next;
    logic                    sat_off_reg, sat_off_next;
    logic                    sat_fold_reg, sat_fold_next;
    out_item_t               out_item_reg, out_item_next;

    logic                    accept;
    logic                    out_free;
    logic [CW-1:0]           fc_ext;
    logic [CW-1:0]           n_eff;
    logic                    active;
    logic                    hit;
    logic [LOAD_W-1:0]       base;
    logic [LOAD_W:0]         off_sum;
    logic [LOAD_W:0]         head_sum;
    logic [LOAD_W-1:0]       head_mod;
    cell_ctrl_t              cell_ctrl;
    logic [LOAD_W-1:0]       load_q [MAX_FOLDS];

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign fc_ext = CW'(fold_count_reg);
    assign n_eff  = (fc_ext == '0) ? CW'(1) : ((fc_ext > FOLD_LIMIT) ? FOLD_LIMIT : fc_ext);
    assign active = (CW'(step_reg) < n_eff);

    assign base     = in_item.first_of_set ? '0 : offset_reg;
    assign off_sum  = {1'b0, base} + {{(LOAD_W + 1 - SIZE_W){1'b0}}, in_item.group_size};
    assign head_sum = {1'b0, load_q[0]} + {{(LOAD_W + 1 - SIZE_W){1'b0}}, size_reg};
    assign hit      = (state_reg == ST_UPDATE) && (step_reg == best_reg);
    assign head_mod = hit ? (head_sum[LOAD_W] ? '1 : head_sum[LOAD_W-1:0]) : load_q[0];

    assign cell_ctrl.clr   = accept && in_item.first_of_set;
    assign cell_ctrl.shift = (state_reg == ST_SCAN) || (state_reg == ST_UPDATE);

    for (genvar g = 0; g < MAX_FOLDS; g++)
    begin : g_cell
        logic [LOAD_W-1:0] feed;
        if (g == MAX_FOLDS - 1)
        begin : g_tail
            assign feed = head_mod;
        end
        else
        begin : g_mid
            assign feed = load_q[g + 1];
        end
        llfa_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (cell_ctrl),
            .d     (feed),
            .q     (load_q[g])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        best_next       = best_reg;
        best_load_next  = best_load_reg;
        offset_next     = offset_reg;
        fold_count_next = cfg_we ? cfg_wdata : fold_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        size_next       = size_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        sat_off_next    = sat_off_reg;
        sat_fold_next   = sat_fold_reg;
        out_item_next   = out_item_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    size_next     = in_item.group_size;
                    start_next    = base;
                    end_next      = off_sum[LOAD_W] ? '1 : off_sum[LOAD_W-1:0];
                    sat_off_next  = off_sum[LOAD_W];
                    sat_fold_next = 1'b0;
                    offset_next   = end_next;
                    step_next     = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (active && ((step_reg == '0) || (load_q[0] < best_load_reg)))
                begin
                    best_next      = step_reg;
                    best_load_next = load_q[0];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (hit)
                begin
                    sat_fold_next = head_sum[LOAD_W];
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.fold_index = FOLD_IDX_W'(best_reg);
                    out_item_next.range_start = start_reg;
                    out_item_next.range_end  = end_reg;
                    out_item_next.saturated  = sat_off_reg || sat_fold_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            best_reg       <= '0;
            offset_reg     <= '0;
            fold_count_reg <= FOLD_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            best_reg       <= best_next;
            offset_reg     <= offset_next;
            fold_count_reg <= fold_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_load_reg <= best_load_next;
        size_reg      <= size_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        sat_off_reg   <= sat_off_next;
        sat_fold_reg  <= sat_fold_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`include "assert_macros.svh"

    `LLFA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_reg == ST_IDLE && !out_valid_reg), "reset must hold idle with no result")
    `LLFA_ASSERT(a_accept_scans, clk, rst_n, accept |=> (state_reg == ST_SCAN && step_reg == '0), "accepted transaction must start the scan")
    `LLFA_ASSERT(a_scan_to_update, clk, rst_n, (state_reg == ST_SCAN && step_reg == LAST_STEP) |=> (state_reg == ST_UPDATE && step_reg == '0), "scan must end in a full update pass")
    `LLFA_ASSERT(a_best_active, clk, rst_n, (state_reg == ST_EMIT) |-> (CW'(best_reg) < n_eff), "chosen fold outside active folds")
    `LLFA_ASSERT(a_result_source, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT), "result appeared without an emit step")

endmodule
